[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers clocked on clk with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/pso_pkg.sv]
// ----------------------------------------------------------------------------
// pso_pkg
// Shared widths, operation codes and register indexes of the particle update.
// ----------------------------------------------------------------------------
package pso_pkg;

	localparam int DIM_DEFAULT = 16;

	localparam int IDX_W     = 4;
	localparam int IDX_RANGE = 1 << IDX_W;
	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 16;
	localparam int RAND_W    = 16;
	localparam int GAIN_FRAC = 12;

	localparam int OP_W         = 2;
	localparam int IN_TDATA_W   = 168;
	localparam int OUT_TDATA_W  = 104;
	localparam int CFG_IDX_W    = 1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_FIT  = 2'd1,
		OP_MOVE = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COG_GAIN    = 1'd0,
		REG_SOCIAL_GAIN = 1'd1
	} reg_idx_t;

endpackage

[src/pso_particle_update.sv]
// ----------------------------------------------------------------------------
// pso_particle_update
// One particle of a particle swarm optimizer with its element stores.
// ----------------------------------------------------------------------------
// The block keeps one particle: position, velocity and personal-best vectors
// of signed Q16.16 elements, a best fitness and a flag that a fitness was
// seen. Each transfer on the slave side carries one operation in s_tuser:
// load an element, report a fitness, move an element, or read an element.
// Every operation returns exactly one transfer on the master side with the
// element at the addressed index after the operation (all zero when the index
// is not below DIM) and the improved and saturated flags. Items are worked
// one at a time by a sequencer around two synchronous memories, each with one
// read port and one write port: position and velocity share one word, the
// personal best has its own. Load, read and a fitness report pass through a
// memory read stage and the result stage; a move passes through one memory
// read, two multiply stages, a sum stage, a position stage and the result
// stage; a fitness report that improves first copies position into personal
// best, walking the store one element per cycle through the shared read port.
// The result register lets the next item be accepted while the previous result waits.
// ----------------------------------------------------------------------------
module pso_particle_update #(
	parameter int DIM = pso_pkg::DIM_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [pso_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pso_pkg::GAIN_W-1:0]       cfg_wdata,
	// Slave side.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// From bit 0: elem_index(4), load_position(32), load_velocity(32),
	// fitness_value(32), global_best_elem(32), rand_cog(16), rand_social(16),
	// zero fill(4).
	input  logic [pso_pkg::IN_TDATA_W-1:0]   s_tdata,
	// op(2).
	input  logic [pso_pkg::OP_W-1:0]         s_tuser,
	// Master side.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// From bit 0: position_out(32), velocity_out(32), personal_best_out(32),
	// improved(1), saturated(1), zero fill(6).
	output logic [pso_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	// Only the first 16 entries can be addressed by elem_index.
	localparam int DEPTH = (DIM < pso_pkg::IDX_RANGE) ? DIM : pso_pkg::IDX_RANGE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = pso_pkg::DATA_W;
	localparam int PW    = 2 * DW;

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RD    = 9'b000000010,
		ST_COPY  = 9'b000000100,
		ST_DRAIN = 9'b000001000,
		ST_M1    = 9'b000010000,
		ST_M2    = 9'b000100000,
		ST_SUM   = 9'b001000000,
		ST_POS   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// Unpacked slave fields.
	logic [pso_pkg::IDX_W-1:0]  in_idx;
	logic signed [DW-1:0]       in_lpos, in_lvel, in_fit, in_gbest;
	logic [pso_pkg::RAND_W-1:0] in_r1, in_r2;

	assign in_idx   = s_tdata[3:0];
	assign in_lpos  = s_tdata[35:4];
	assign in_lvel  = s_tdata[67:36];
	assign in_fit   = s_tdata[99:68];
	assign in_gbest = s_tdata[131:100];
	assign in_r1    = s_tdata[147:132];
	assign in_r2    = s_tdata[163:148];

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Configuration registers.
	logic [pso_pkg::GAIN_W-1:0] cog_gain_q, social_gain_q;

	// Captured item.
	pso_pkg::op_t               op_q;
	logic [AW-1:0]              addr_q;
	logic                       idx_ok_q;
	logic signed [DW-1:0]       lpos_q, lvel_q, fit_q, gbest_q;
	logic [pso_pkg::RAND_W-1:0] r1_q, r2_q;

	// Particle fitness state.
	logic signed [DW-1:0] best_fitness_q;
	logic                 fitness_seen_q;

	// Memories and their registered read data.
	logic [PW-1:0] mem_pv [DEPTH];
	logic [DW-1:0] mem_pb [DEPTH];
	logic [PW-1:0] rd_pv_q;
	logic [DW-1:0] rd_pb_q;
	logic [AW-1:0] rd_addr;
	logic          pv_we;
	logic [PW-1:0] pv_wdata;

	// Copy walk.
	logic [AW-1:0] cp_q;
	logic          copy_wr_q;
	logic [AW-1:0] copy_addr_q;
	logic          cp_last;

	// Move datapath.
	logic [pso_pkg::GAIN_W-1:0] g1_q, g2_q;
	logic signed [DW:0]         d1_q, d2_q;
	logic signed [DW-1:0]       pos_q, vel_q, nv_q;
	logic signed [49:0]         prod1_q, prod2_q;
	logic signed [50:0]         acc_q;
	logic                       vsat_q;

	// Pending result and the output register.
	logic signed [DW-1:0] res_pos_q, res_vel_q, res_pb_q;
	logic                 res_imp_q, res_sat_q;
	logic signed [DW-1:0] out_pos_q, out_vel_q, out_pb_q;
	logic                 out_imp_q, out_sat_q;
	logic                 m_tvalid_q;
	logic                 out_load;

	// Combinational helpers.
	logic signed [DW-1:0]   rd_pos, rd_vel;
	logic                   improve;
	logic [2*pso_pkg::GAIN_W-1:0] gp1, gp2;
	logic signed [50:0]     sum_w;
	logic signed [38:0]     q_w;
	logic                   q_fits;
	logic signed [DW-1:0]   nv_w;
	logic signed [DW:0]     np_w;
	logic                   np_ovf;
	logic signed [DW-1:0]   np_clamp;

	assign rd_pos  = rd_pv_q[DW-1:0];
	assign rd_vel  = rd_pv_q[PW-1:DW];
	assign improve = !fitness_seen_q || (fit_q > best_fitness_q);
	assign cp_last = (cp_q == AW'(DEPTH - 1));

	assign gp1 = cog_gain_q * r1_q;
	assign gp2 = social_gain_q * r2_q;

	// New velocity: round half up, floor divide by 4096, clamp to 32 bits.
	assign sum_w  = acc_q + {prod2_q[49], prod2_q} + 51'sd2048;
	assign q_w    = sum_w[50:12];
	assign q_fits = (q_w[38:31] == {8{q_w[31]}});
	always_comb begin
		if (q_fits) begin
			nv_w = q_w[31:0];
		end else if (q_w[38]) begin
			nv_w = {1'b1, {(DW-1){1'b0}}};
		end else begin
			nv_w = {1'b0, {(DW-1){1'b1}}};
		end
	end

	// New position from the clamped new velocity.
	assign np_w   = {pos_q[DW-1], pos_q} + {nv_q[DW-1], nv_q};
	assign np_ovf = (np_w[DW] != np_w[DW-1]);
	always_comb begin
		if (!np_ovf) begin
			np_clamp = np_w[DW-1:0];
		end else if (np_w[DW]) begin
			np_clamp = {1'b1, {(DW-1){1'b0}}};
		end else begin
			np_clamp = {1'b0, {(DW-1){1'b1}}};
		end
	end

	// The read port serves the item at acceptance and the copy walk later.
	always_comb begin
		if (state_q == ST_COPY) begin
			rd_addr = cp_q;
		end else begin
			rd_addr = in_idx[AW-1:0];
		end
	end

	// Position and velocity are written by a load and at the end of a move.
	assign pv_we    = ((state_q == ST_RD) && (op_q == pso_pkg::OP_LOAD) && idx_ok_q)
	               || ((state_q == ST_POS) && idx_ok_q);
	assign pv_wdata = (state_q == ST_POS) ? {nv_q, np_clamp} : {lvel_q, lpos_q};

	always_ff @(posedge clk) begin
		if (pv_we) begin
			mem_pv[addr_q] <= pv_wdata;
		end
		rd_pv_q <= mem_pv[rd_addr];
	end

	// The copy writes each position in the cycle after it was read.
	always_ff @(posedge clk) begin
		if (copy_wr_q) begin
			mem_pb[copy_addr_q] <= rd_pos;
		end
		rd_pb_q <= mem_pb[rd_addr];
	end

	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				if ((op_q == pso_pkg::OP_MOVE) && idx_ok_q) begin
					state_d = ST_M1;
				end else if ((op_q == pso_pkg::OP_FIT) && improve) begin
					state_d = ST_COPY;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_COPY: begin
				if (cp_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FIN;
			ST_M1:    state_d = ST_M2;
			ST_M2:    state_d = ST_SUM;
			ST_SUM:   state_d = ST_POS;
			ST_POS:   state_d = ST_FIN;
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cog_gain_q     <= pso_pkg::GAIN_RESET;
			social_gain_q  <= pso_pkg::GAIN_RESET;
			best_fitness_q <= '0;
			fitness_seen_q <= 1'b0;
			cp_q           <= '0;
			copy_wr_q      <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			copy_wr_q <= (state_q == ST_COPY);
			if (cfg_we) begin
				case (pso_pkg::reg_idx_t'(cfg_index))
					pso_pkg::REG_COG_GAIN:    cog_gain_q    <= cfg_wdata;
					pso_pkg::REG_SOCIAL_GAIN: social_gain_q <= cfg_wdata;
					default: ;
				endcase
			end
			if ((state_q == ST_RD) && (op_q == pso_pkg::OP_FIT) && improve) begin
				best_fitness_q <= fit_q;
				fitness_seen_q <= 1'b1;
			end
			if (state_q == ST_COPY) begin
				cp_q <= cp_last ? '0 : cp_q + AW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		copy_addr_q <= cp_q;
		if (accept) begin
			op_q     <= pso_pkg::op_t'(s_tuser);
			addr_q   <= in_idx[AW-1:0];
			idx_ok_q <= (32'(in_idx) < 32'(DIM));
			lpos_q   <= in_lpos;
			lvel_q   <= in_lvel;
			fit_q    <= in_fit;
			gbest_q  <= in_gbest;
			r1_q     <= in_r1;
			r2_q     <= in_r2;
		end
		case (state_q)
			ST_RD: begin
				pos_q     <= rd_pos;
				vel_q     <= rd_vel;
				g1_q      <= gp1[2*pso_pkg::GAIN_W-1:pso_pkg::GAIN_W];
				g2_q      <= gp2[2*pso_pkg::GAIN_W-1:pso_pkg::GAIN_W];
				d1_q      <= {rd_pb_q[DW-1], rd_pb_q} - {rd_pos[DW-1], rd_pos};
				d2_q      <= {gbest_q[DW-1], gbest_q} - {rd_pos[DW-1], rd_pos};
				res_imp_q <= (op_q == pso_pkg::OP_FIT) && improve;
				res_sat_q <= 1'b0;
				res_pos_q <= (op_q == pso_pkg::OP_LOAD) ? lpos_q : rd_pos;
				res_vel_q <= (op_q == pso_pkg::OP_LOAD) ? lvel_q : rd_vel;
				if ((op_q == pso_pkg::OP_FIT) && improve) begin
					res_pb_q <= rd_pos;
				end else begin
					res_pb_q <= rd_pb_q;
				end
			end
			ST_M1: begin
				prod1_q <= $signed({1'b0, g1_q}) * d1_q;
			end
			ST_M2: begin
				prod2_q <= $signed({1'b0, g2_q}) * d2_q;
				acc_q   <= {{7{vel_q[DW-1]}}, vel_q, {pso_pkg::GAIN_FRAC{1'b0}}}
				         + {prod1_q[49], prod1_q};
			end
			ST_SUM: begin
				nv_q   <= nv_w;
				vsat_q <= !q_fits;
			end
			ST_POS: begin
				res_pos_q <= np_clamp;
				res_vel_q <= nv_q;
				res_sat_q <= vsat_q || np_ovf;
			end
			default: ;
		endcase
		if (out_load) begin
			out_pos_q <= idx_ok_q ? res_pos_q : '0;
			out_vel_q <= idx_ok_q ? res_vel_q : '0;
			out_pb_q  <= idx_ok_q ? res_pb_q  : '0;
			out_imp_q <= res_imp_q;
			out_sat_q <= res_sat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_sat_q, out_imp_q, out_pb_q, out_vel_q, out_pos_q};

`include "assert_macros.svh"

	`ASSERT_NEXT(a_accept_reads, accept, state_q == ST_RD, "accepted item did not start with a read")
	`ASSERT_ALWAYS(a_copy_window, !copy_wr_q || state_q == ST_COPY || state_q == ST_DRAIN, "copy write outside the copy walk")
	`ASSERT_ALWAYS(a_seen_sticky, !$fell(fitness_seen_q), "fitness seen flag cleared")
	`ASSERT_ALWAYS(a_improved_seen, !(m_tvalid_q && out_imp_q) || fitness_seen_q, "improvement reported with no fitness seen")

endmodule
